/* src/vtts_pkg.sv */
package vtts_pkg;

   localparam int GRID_SIZE_DEF = 32;
   localparam int FRAC_BITS_DEF = 16;
   localparam int POS_W = 24;
   localparam int COMP_W = 32;
   localparam int NCORNER = 8;
   localparam int NCOMP = 6;
   localparam int TENSOR_W = NCOMP * COMP_W;

   typedef enum logic [1:0] {
      FUNC_WRITE  = 2'd0,
      FUNC_SAMPLE = 2'd1,
      FUNC_READ   = 2'd2
   } func_type;

   typedef enum logic {
      CSR_STRESS_PRESENT = 1'b0,
      CSR_STRAIN_PRESENT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [1:0]               func;
      logic                     field_sel;
      logic signed [POS_W-1:0]  pos_x;
      logic signed [POS_W-1:0]  pos_y;
      logic signed [POS_W-1:0]  pos_z;
      logic                     is_occupied;
      logic signed [COMP_W-1:0] in_xx;
      logic signed [COMP_W-1:0] in_yy;
      logic signed [COMP_W-1:0] in_zz;
      logic signed [COMP_W-1:0] in_xy;
      logic signed [COMP_W-1:0] in_yz;
      logic signed [COMP_W-1:0] in_xz;
   } req_type;

   typedef struct packed {
      logic                     valid_res;
      logic signed [COMP_W-1:0] out_xx;
      logic signed [COMP_W-1:0] out_yy;
      logic signed [COMP_W-1:0] out_zz;
      logic signed [COMP_W-1:0] out_xy;
      logic signed [COMP_W-1:0] out_yz;
      logic signed [COMP_W-1:0] out_xz;
   } rsp_type;

   typedef struct packed {
      logic       idle;
      logic       capture;
      logic       wr_go;
      logic       rd_take;
      logic       occ_take;
      logic       fetch_issue;
      logic       fetch_take;
      logic       lerp_go;
      logic       set_valid;
      logic       out_load;
      logic [2:0] idx;
   } ctl_type;

   typedef struct packed {
      logic       clr_done;
      logic [1:0] func;
      logic       field_on;
      logic       ingrid;
      logic       any_ok;
      logic       out_free;
   } sts_type;

   // nearest occupied corner by hamming distance, lowest index on a tie
   function automatic logic [2:0] best_src(input logic [7:0] ok, input logic [2:0] n);
      logic [2:0] best;
      logic [2:0] bestd;
      logic [2:0] x;
      logic [2:0] d;
      best = 3'd0;
      bestd = 3'd4;
      for (int m = 0; m < NCORNER; m++) begin
         x = n ^ 3'(m);
         d = 3'(x[0]) + 3'(x[1]) + 3'(x[2]);
         if (ok[m] && (d < bestd)) begin
            bestd = d;
            best = 3'(m);
         end
      end
      if (ok[n]) begin
         best = n;
      end
      return best;
   endfunction

endpackage

/* src/vtts_ram.sv */
module vtts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

/* src/vtts_ctrl.sv */
module vtts_ctrl
   import vtts_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  sts_type sts,
   output ctl_type ctl
);

   typedef enum logic [9:0] {
      S_CLEAR    = 10'b0000000001,
      S_IDLE     = 10'b0000000010,
      S_DECODE   = 10'b0000000100,
      S_WRITE    = 10'b0000001000,
      S_RD_ISSUE = 10'b0000010000,
      S_RD_TAKE  = 10'b0000100000,
      S_OCC      = 10'b0001000000,
      S_FETCH    = 10'b0010000000,
      S_LERP     = 10'b0100000000,
      S_DONE     = 10'b1000000000
   } state_type;

   state_type  state_ff, state_in;
   logic [3:0] cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      cnt_in = 4'd0;
      ctl = '0;
      ctl.idx = cnt_ff[2:0];
      case (state_ff)
         S_CLEAR: begin
            if (sts.clr_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            ctl.idle = 1'b1;
            ctl.capture = req_valid;
            if (req_valid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (sts.func)
               FUNC_WRITE:  state_in = S_WRITE;
               FUNC_READ:   state_in = (sts.field_on && sts.ingrid) ? S_RD_ISSUE : S_DONE;
               FUNC_SAMPLE: state_in = sts.field_on ? S_OCC : S_DONE;
               default:     state_in = S_DONE;
            endcase
         end
         S_WRITE: begin
            ctl.wr_go = 1'b1;
            state_in = S_DONE;
         end
         S_RD_ISSUE: begin
            state_in = S_RD_TAKE;
         end
         S_RD_TAKE: begin
            ctl.rd_take = 1'b1;
            state_in = S_DONE;
         end
         S_OCC: begin
            // read occupancy of corner cnt, collect corner cnt-1
            ctl.occ_take = (cnt_ff != 4'd0);
            if (cnt_ff == 4'd8) begin
               state_in = S_FETCH;
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         S_FETCH: begin
            ctl.fetch_issue = 1'b1;
            ctl.fetch_take = (cnt_ff != 4'd0);
            if ((cnt_ff == 4'd0) && !sts.any_ok) begin
               state_in = S_DONE;
            end else if (cnt_ff == 4'd8) begin
               state_in = S_LERP;
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         S_LERP: begin
            ctl.lerp_go = 1'b1;
            if (cnt_ff == 4'd6) begin
               ctl.set_valid = 1'b1;
               state_in = S_DONE;
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         S_DONE: begin
            if (sts.out_free) begin
               ctl.out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cnt_ff <= 4'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

/* src/vtts_dpath.sv */
module vtts_dpath
   import vtts_pkg::*;
#(
   parameter int GRID_SIZE = GRID_SIZE_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  req_type req_data,
   input  ctl_type ctl,
   output sts_type sts,
   input  logic    csr_we,
   input  logic    csr_index,
   input  logic    csr_wdata,
   input  logic    rsp_stall,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int IW = POS_W - FRAC_BITS;
   localparam int AW = $clog2(GRID_SIZE);
   localparam int CW = (IW + 1 > AW + 2) ? IW + 1 : AW + 2;
   localparam int NVOX = GRID_SIZE * GRID_SIZE * GRID_SIZE;
   localparam int VA = $clog2(NVOX);
   localparam int PW = 34 + FRAC_BITS;
   localparam logic [PW-1:0] HALF = PW'(2 ** (FRAC_BITS - 1));

   req_type item_ff, item_in;
   logic [1:0] present_ff, present_in;
   logic clr_busy_ff, clr_busy_in;
   logic [VA-1:0] clr_cnt_ff, clr_cnt_in;
   logic [7:0] ok_ff, ok_in;
   logic inb_d_ff;
   logic res_valid_ff, res_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   logic signed [COMP_W-1:0] c_ff [NCORNER][NCOMP];
   logic signed [COMP_W-1:0] c_in [NCORNER][NCOMP];

   logic signed [IW-1:0] ipx, ipy, ipz;
   logic [2:0] corner;
   logic signed [CW-1:0] cx, cy, cz;
   logic inb;
   logic [VA-1:0] vox;

   logic occ_we;
   logic [VA-1:0] occ_waddr;
   logic occ_wdata, occ_rdata;
   logic ten_we;
   logic [TENSOR_W-1:0] ten_wdata, ten_rdata;
   logic [FRAC_BITS-1:0] frac;
   logic signed [COMP_W-1:0] lane_b [NCOMP];
   logic signed [COMP_W-1:0] lane_r [NCOMP];

   assign ipx = item_ff.pos_x[POS_W-1:FRAC_BITS];
   assign ipy = item_ff.pos_y[POS_W-1:FRAC_BITS];
   assign ipz = item_ff.pos_z[POS_W-1:FRAC_BITS];

   assign corner = ctl.fetch_issue ? best_src(ok_ff, ctl.idx) : ctl.idx;

   assign cx = $signed({{(CW-IW){ipx[IW-1]}}, ipx}) + $signed({{(CW-1){1'b0}}, corner[0]});
   assign cy = $signed({{(CW-IW){ipy[IW-1]}}, ipy}) + $signed({{(CW-1){1'b0}}, corner[1]});
   assign cz = $signed({{(CW-IW){ipz[IW-1]}}, ipz}) + $signed({{(CW-1){1'b0}}, corner[2]});

   assign inb = !cx[CW-1] && (cx < $signed(CW'(GRID_SIZE)))
             && !cy[CW-1] && (cy < $signed(CW'(GRID_SIZE)))
             && !cz[CW-1] && (cz < $signed(CW'(GRID_SIZE)));

   assign vox = VA'(VA'(cz[AW-1:0]) * VA'(GRID_SIZE * GRID_SIZE))
              + VA'(VA'(cy[AW-1:0]) * VA'(GRID_SIZE))
              + VA'(cx[AW-1:0]);

   // occupancy: cleared after reset, one voxel a cycle
   assign occ_we = clr_busy_ff || (ctl.wr_go && inb);
   assign occ_waddr = clr_busy_ff ? clr_cnt_ff : vox;
   assign occ_wdata = !clr_busy_ff && item_ff.is_occupied;

   vtts_ram #(
      .WIDTH (1),
      .DEPTH (NVOX)
   ) u_occ_ram (
      .clock (clock),
      .we    (occ_we),
      .waddr (occ_waddr),
      .wdata (occ_wdata),
      .raddr (vox),
      .rdata (occ_rdata)
   );

   assign ten_we = ctl.wr_go && inb;
   assign ten_wdata = {item_ff.in_xz, item_ff.in_yz, item_ff.in_xy,
                       item_ff.in_zz, item_ff.in_yy, item_ff.in_xx};

   vtts_ram #(
      .WIDTH (TENSOR_W),
      .DEPTH (2 ** (VA + 1))
   ) u_tensor_ram (
      .clock (clock),
      .we    (ten_we),
      .waddr ({item_ff.field_sel, vox}),
      .wdata (ten_wdata),
      .raddr ({item_ff.field_sel, vox}),
      .rdata (ten_rdata)
   );

   // lerp phase: x for steps 0..3, y for 4..5, z for 6
   always_comb begin
      if (!ctl.idx[2]) begin
         frac = item_ff.pos_x[FRAC_BITS-1:0];
      end else if (ctl.idx[1:0] != 2'd2) begin
         frac = item_ff.pos_y[FRAC_BITS-1:0];
      end else begin
         frac = item_ff.pos_z[FRAC_BITS-1:0];
      end
   end

   for (genvar t = 0; t < NCOMP; t++) begin : g_lane
      logic signed [COMP_W-1:0] a;
      logic signed [COMP_W:0]   d;
      logic signed [PW-1:0]     p;
      logic [PW-1:0]            pt;
      logic signed [COMP_W+1:0] sum;

      assign a = c_ff[0][t];
      assign lane_b[t] = !ctl.idx[2] ? c_ff[1][t]
                       : (ctl.idx[1:0] != 2'd2) ? c_ff[2][t] : c_ff[4][t];
      // a + round((b - a) * f / one)
      assign d = $signed({lane_b[t][COMP_W-1], lane_b[t]}) - $signed({a[COMP_W-1], a});
      assign p = d * $signed({1'b0, frac});
      assign pt = p + HALF;
      assign sum = $signed({{2{a[COMP_W-1]}}, a}) + $signed(pt[PW-1:FRAC_BITS]);
      assign lane_r[t] = sum[COMP_W-1:0];
   end

   always_comb begin
      c_in = c_ff;
      if (ctl.rd_take) begin
         for (int t = 0; t < NCOMP; t++) begin
            c_in[0][t] = ten_rdata[t*COMP_W +: COMP_W];
         end
      end else if (ctl.fetch_take) begin
         for (int n = 0; n < NCORNER - 1; n++) begin
            c_in[n] = c_ff[n+1];
         end
         for (int t = 0; t < NCOMP; t++) begin
            c_in[NCORNER-1][t] = ten_rdata[t*COMP_W +: COMP_W];
         end
      end else if (ctl.lerp_go) begin
         if (!ctl.idx[2]) begin
            for (int n = 0; n < 6; n++) begin
               c_in[n] = c_ff[n+2];
            end
            c_in[6] = lane_r;
         end else if (ctl.idx[1:0] != 2'd2) begin
            for (int n = 0; n < 4; n++) begin
               c_in[n] = c_ff[n+4];
            end
            c_in[4] = lane_r;
         end else begin
            c_in[0] = lane_r;
         end
      end
   end

   always_comb begin
      item_in = ctl.capture ? req_data : item_ff;
      ok_in = ctl.occ_take ? {inb_d_ff && occ_rdata, ok_ff[7:1]} : ok_ff;

      res_valid_in = res_valid_ff;
      if (ctl.capture) begin
         res_valid_in = 1'b0;
      end else if (ctl.rd_take) begin
         res_valid_in = occ_rdata;
      end else if (ctl.set_valid) begin
         res_valid_in = 1'b1;
      end

      present_in = present_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_STRESS_PRESENT: present_in[0] = csr_wdata;
            CSR_STRAIN_PRESENT: present_in[1] = csr_wdata;
            default: present_in = present_ff;
         endcase
      end

      clr_busy_in = clr_busy_ff;
      clr_cnt_in = clr_cnt_ff;
      if (clr_busy_ff) begin
         clr_cnt_in = clr_cnt_ff + VA'(1);
         if (clr_cnt_ff == VA'(NVOX - 1)) begin
            clr_busy_in = 1'b0;
         end
      end

      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (ctl.out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in = '0;
         if (res_valid_ff) begin
            rsp_data_in.valid_res = 1'b1;
            rsp_data_in.out_xx = c_ff[0][0];
            rsp_data_in.out_yy = c_ff[0][1];
            rsp_data_in.out_zz = c_ff[0][2];
            rsp_data_in.out_xy = c_ff[0][3];
            rsp_data_in.out_yz = c_ff[0][4];
            rsp_data_in.out_xz = c_ff[0][5];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= 2'b00;
         clr_busy_ff <= 1'b1;
         clr_cnt_ff <= '0;
         res_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         present_ff <= present_in;
         clr_busy_ff <= clr_busy_in;
         clr_cnt_ff <= clr_cnt_in;
         res_valid_ff <= res_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      ok_ff <= ok_in;
      inb_d_ff <= inb;
      c_ff <= c_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign sts.clr_done = !clr_busy_ff;
   assign sts.func = item_ff.func;
   assign sts.field_on = present_ff[item_ff.field_sel];
   assign sts.ingrid = inb;
   assign sts.any_ok = |ok_ff;
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule

/* src/voxel_tensor_trilinear_sampler_top.sv */
// voxel tensor trilinear sampler
// req channel (req_valid, req_stall, req_data) takes one transaction at a time:
// a voxel write, a voxel read or a trilinear sample of the stress or strain
// field. every transaction yields exactly one rsp transaction in order.
// csr_we writes the field-present bits (index 0 stress, 1 strain); the user
// must write them only while idle, as the block itself does not enforce it.
// a sample takes 8 occupancy reads, 8 corner tensor reads and 7 lerp steps,
// all through the single read port of each store.
// reads of an absent field or outside the grid, and samples of an absent field
// or with no occupied corner, finish early. req_stall is high while a
// transaction is in work, so a new one waits until the last one is done.
// reset clears the field-present bits and then sweeps all GRID_SIZE**3 voxels
// of the occupancy store, during which req_stall stays high.
// the result sits in an output register: while rsp_stall is high rsp_data holds,
// and the next transaction is still accepted and worked up to its result.
module voxel_tensor_trilinear_sampler_top
   import vtts_pkg::*;
#(
   parameter int GRID_SIZE = GRID_SIZE_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data,
   input  logic    csr_we,
   input  logic    csr_index,
   input  logic    csr_wdata
);

   ctl_type ctl;
   sts_type sts;

   vtts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .sts       (sts),
      .ctl       (ctl)
   );

   vtts_dpath #(
      .GRID_SIZE (GRID_SIZE),
      .FRAC_BITS (FRAC_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .ctl       (ctl),
      .sts       (sts),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   assign req_stall = !ctl.idle;

endmodule

/* src/vtts_checker.sv */
module vtts_checker
   import vtts_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data,
   input logic    csr_we,
   input logic    csr_index,
   input logic    csr_wdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled rsp transaction changed");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.valid_res |->
         rsp_data.out_xx == 0 && rsp_data.out_yy == 0 && rsp_data.out_zz == 0 &&
         rsp_data.out_xy == 0 && rsp_data.out_yz == 0 && rsp_data.out_xz == 0)
      else $error("invalid result carries nonzero tensor");

   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second transaction taken while one is in work");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> req_stall && !rsp_valid)
      else $error("block not quiet after reset");

endmodule

bind voxel_tensor_trilinear_sampler_top vtts_checker u_vtts_checker (.*);
